// ===== src/obsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill package
// Shared widths, codes, constants and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package obsf_pkg;

  localparam int unsigned PriceW = 40;
  localparam int unsigned SizeW  = 48;
  localparam int unsigned QuoteW = 48;
  localparam int unsigned CountW = 7;
  localparam int unsigned BaseW  = 56;
  localparam int unsigned DvdW   = 80;
  localparam int unsigned DsrW   = 56;
  localparam int unsigned SlipW  = 32;

  // Request codes.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Percent scale with 16 fraction bits: 100 * 65536.
  localparam logic [22:0] SLIP_SCALE = 23'd6553600;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic mul_lo;
    logic mul_hi;
    logic take;
    logic part_go;
    logic part_end;
    logic avg_go;
    logic avg_end;
    logic slip_mul;
    logic slip_go;
    logic slip_end;
    logic out_empty;
    logic out_query;
  } obsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic rem_zero;
    logic fits;
    logic more;
    logic base_zero;
    logic slip_en;
    logic div_done;
  } obsf_status_t;

endpackage

// ===== src/obsf_div.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill divider
// Restoring radix-2 divider, one quotient bit per cycle over the full
// dividend width.
// ----------------------------------------------------------------------------
module obsf_div
  import obsf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DvdW-1:0]   dividend_i,
  input  logic [DsrW-1:0]   divisor_i,
  output logic              done_o,
  output logic [DvdW-1:0]   quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [6:0]        cnt_q;
  logic [DvdW-1:0]   dvd_q;
  logic [DsrW-1:0]   rem_q;
  logic [DsrW-1:0]   dsr_q;
  logic [DsrW:0]     trial;
  logic              ge;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? DsrW'(trial - {1'b0, dsr_q}) : trial[DsrW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== src/obsf_datapath.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill datapath
// Level tables, level counts, sweep accumulators, cost multiplier, divider
// and the result register.
// ----------------------------------------------------------------------------
module obsf_datapath
  import obsf_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    ask_side_i,
  input  logic [5:0]              level_index_i,
  input  logic [PriceW-1:0]       level_price_i,
  input  logic [SizeW-1:0]        level_size_i,
  input  logic [QuoteW-1:0]       quote_amount_i,
  input  obsf_cmd_t               cmd_i,
  output obsf_status_t            status_o,
  output logic                    accepted_o,
  output logic [QuoteW-1:0]       spent_total_o,
  output logic [SizeW-1:0]        base_total_o,
  output logic [CountW-1:0]       depth_used_o,
  output logic                    filled_all_o,
  output logic [PriceW-1:0]       top_price_o,
  output logic [PriceW-1:0]       average_price_o,
  output logic signed [SlipW-1:0] slippage_percent_o
);

  localparam int unsigned Entries = 2 * BOOK_DEPTH;
  localparam int unsigned AW      = (Entries > 1) ? $clog2(Entries) : 1;

  logic [PriceW-1:0] price_mem [Entries];
  logic [SizeW-1:0]  size_mem  [Entries];
  logic [PriceW-1:0] rd_price_q;
  logic [SizeW-1:0]  rd_size_q;

  logic [CountW-1:0] bid_cnt_q, ask_cnt_q, cnt_q, n_q;
  logic              side_q;
  logic [QuoteW-1:0] rem_q, spent_q;
  logic [BaseW-1:0]  base_q;
  logic [PriceW-1:0] best_q, avg_q;
  logic [SlipW-1:0]  slip_q;
  logic [63:0]       prod_q;
  logic [BaseW-1:0]  cost_q;
  logic [62:0]       diffm_q;
  logic              neg_q;

  logic              load_ok;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BaseW-1:0]  cost_hi;
  logic [PriceW-1:0] diff;
  logic [62:0]       diffm;
  logic              div_start;
  logic [DvdW-1:0]   div_dvd;
  logic [DsrW-1:0]   div_dsr;
  logic              div_done;
  logic [DvdW-1:0]   div_q;
  logic [SlipW-1:0]  slip_mag;

  // Load checks and table addresses.
  assign load_ok = (level_price_i != '0) && (level_size_i != '0) &&
                   (int'(level_index_i) < BOOK_DEPTH);
  assign wr_addr = AW'((ask_side_i ? BOOK_DEPTH : 0) + int'(level_index_i));
  assign rd_addr = AW'((side_q ? BOOK_DEPTH : 0) + int'(n_q));

  // Level tables: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      price_mem[wr_addr] <= level_price_i;
      size_mem[wr_addr]  <= level_size_i;
    end
    if (cmd_i.rd) begin
      rd_price_q <= price_mem[rd_addr];
      rd_size_q  <= size_mem[rd_addr];
    end
  end

  // Level counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_cnt_q <= '0;
      ask_cnt_q <= '0;
    end else if (cmd_i.load && load_ok) begin
      if (ask_side_i) begin
        ask_cnt_q <= CountW'(level_index_i) + 7'd1;
      end else begin
        bid_cnt_q <= CountW'(level_index_i) + 7'd1;
      end
    end
  end

  // Upper partial products of the level cost.
  assign cost_hi = BaseW'(rd_price_q) * BaseW'(rd_size_q[47:32]) +
                   BaseW'(rd_price_q[39:32]) * BaseW'(rd_size_q[31:0]) +
                   BaseW'(prod_q[63:32]);

  // Slippage magnitude before division.
  assign diff  = (avg_q >= best_q) ? avg_q - best_q : best_q - avg_q;
  assign diffm = 63'(diff) * 63'(SLIP_SCALE);

  // Divider operand selection.
  assign div_start = cmd_i.part_go | cmd_i.avg_go | cmd_i.slip_go;
  always_comb begin
    div_dvd = {17'd0, diffm_q};
    div_dsr = DsrW'(best_q);
    if (cmd_i.part_go) begin
      div_dvd = {rem_q, 32'd0};
      div_dsr = DsrW'(rd_price_q);
    end else if (cmd_i.avg_go) begin
      div_dvd = {spent_q, 32'd0};
      div_dsr = base_q;
    end
  end

  obsf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Saturated slippage magnitude and sign.
  always_comb begin
    if (neg_q) begin
      slip_mag = (div_q > 80'h80000000) ? 32'h80000000 : div_q[31:0];
      slip_mag = 32'd0 - slip_mag;
    end else begin
      slip_mag = (div_q > 80'h7FFFFFFF) ? 32'h7FFFFFFF : div_q[31:0];
    end
  end

  // Sweep accumulators.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      side_q  <= ask_side_i;
      cnt_q   <= ask_side_i ? ask_cnt_q : bid_cnt_q;
      rem_q   <= quote_amount_i;
      spent_q <= '0;
      base_q  <= '0;
      n_q     <= '0;
      avg_q   <= '0;
      slip_q  <= '0;
    end
    if (cmd_i.mul_lo) begin
      prod_q <= 64'(rd_price_q[31:0]) * 64'(rd_size_q[31:0]);
      if (n_q == '0) begin
        best_q <= rd_price_q;
      end
    end
    if (cmd_i.mul_hi) begin
      cost_q <= cost_hi;
    end
    if (cmd_i.take) begin
      spent_q <= spent_q + cost_q[QuoteW-1:0];
      base_q  <= base_q + BaseW'(rd_size_q);
      rem_q   <= rem_q - cost_q[QuoteW-1:0];
      n_q     <= n_q + 7'd1;
    end
    if (cmd_i.part_end) begin
      spent_q <= spent_q + rem_q;
      base_q  <= base_q + ((|div_q[79:48]) ? BaseW'(48'hFFFFFFFFFFFF)
                                          : BaseW'(div_q[47:0]));
      rem_q   <= '0;
      n_q     <= n_q + 7'd1;
    end
    if (cmd_i.avg_end) begin
      avg_q <= (|div_q[79:40]) ? 40'hFFFFFFFFFF : div_q[39:0];
    end
    if (cmd_i.slip_mul) begin
      diffm_q <= diffm;
      neg_q   <= side_q ? (avg_q < best_q) : (best_q < avg_q);
    end
    if (cmd_i.slip_end) begin
      slip_q <= slip_mag;
    end
  end

  // Status toward the controller.
  assign status_o.count_zero = (ask_side_i ? ask_cnt_q : bid_cnt_q) == '0;
  assign status_o.rem_zero   = rem_q == '0;
  assign status_o.fits       = {8'd0, rem_q} >= cost_q;
  assign status_o.more       = (rem_q != cost_q[QuoteW-1:0]) && ((n_q + 7'd1) < cnt_q);
  assign status_o.base_zero  = base_q == '0;
  assign status_o.slip_en    = (best_q != '0) && (avg_q != '0);
  assign status_o.div_done   = div_done;

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.out_empty) begin
      accepted_o         <= cmd_i.load && load_ok;
      spent_total_o      <= '0;
      base_total_o       <= '0;
      depth_used_o       <= '0;
      filled_all_o       <= 1'b0;
      top_price_o        <= '0;
      average_price_o    <= '0;
      slippage_percent_o <= '0;
    end else if (cmd_i.out_query) begin
      accepted_o         <= 1'b1;
      spent_total_o      <= spent_q;
      base_total_o       <= (|base_q[55:48]) ? 48'hFFFFFFFFFFFF : base_q[47:0];
      depth_used_o       <= n_q;
      filled_all_o       <= rem_q == '0;
      top_price_o        <= best_q;
      average_price_o    <= avg_q;
      slippage_percent_o <= slip_q;
    end
  end

endmodule

// ===== src/obsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill controller
// Sequences loads and the level-by-level sweep of a fill query, and owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
module obsf_ctrl
  import obsf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         req_type_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  obsf_status_t status_i,
  output obsf_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MUL_LO, ST_MUL_HI, ST_CMP, ST_DIV_PART, ST_FINISH,
    ST_DIV_AVG, ST_SLIP_MUL, ST_SLIP_GO, ST_DIV_SLIP, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, accept;

  // Result register is free when empty or being taken this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.load  = 1'b1;
            out_valid_d = 1'b1;
          end else if (status_i.count_zero) begin
            cmd_o.out_empty = 1'b1;
            out_valid_d     = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = status_i.rem_zero ? ST_FINISH : ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.fits) begin
          cmd_o.take = 1'b1;
          state_d    = status_i.more ? ST_RD : ST_FINISH;
        end else begin
          cmd_o.part_go = 1'b1;
          state_d       = ST_DIV_PART;
        end
      end
      ST_DIV_PART: begin
        if (status_i.div_done) begin
          cmd_o.part_end = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.base_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.avg_go = 1'b1;
          state_d      = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (status_i.div_done) begin
          cmd_o.avg_end = 1'b1;
          state_d       = ST_SLIP_MUL;
        end
      end
      ST_SLIP_MUL: begin
        if (status_i.slip_en) begin
          cmd_o.slip_mul = 1'b1;
          state_d        = ST_SLIP_GO;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SLIP_GO: begin
        cmd_o.slip_go = 1'b1;
        state_d       = ST_DIV_SLIP;
      end
      ST_DIV_SLIP: begin
        if (status_i.div_done) begin
          cmd_o.slip_end = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_query = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/order_book_sweep_fill_unit.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill unit
// A load's result shows the next cycle; loads stream one per cycle while the
// result channel is not stalled. A query walks its side level by level, and
// runs up to three divisions on one shared divider (partial level, average,
// slippage). One query at a time.
// Reset clears both level counts and the handshake; table contents stay
// undefined until loaded.
// ----------------------------------------------------------------------------
module order_book_sweep_fill_unit
  import obsf_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    req_type_i,
  input  logic                    ask_side_i,
  input  logic [5:0]              level_index_i,
  input  logic [PriceW-1:0]       level_price_i,
  input  logic [SizeW-1:0]        level_size_i,
  input  logic [QuoteW-1:0]       quote_amount_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    accepted_o,
  output logic [QuoteW-1:0]       spent_total_o,
  output logic [SizeW-1:0]        base_total_o,
  output logic [CountW-1:0]       depth_used_o,
  output logic                    filled_all_o,
  output logic [PriceW-1:0]       top_price_o,
  output logic [PriceW-1:0]       average_price_o,
  output logic signed [SlipW-1:0] slippage_percent_o
);

  obsf_cmd_t    cmd;
  obsf_status_t status;

  // Sequencing and handshake.
  obsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Tables and arithmetic.
  obsf_datapath #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ask_side_i         (ask_side_i),
    .level_index_i      (level_index_i),
    .level_price_i      (level_price_i),
    .level_size_i       (level_size_i),
    .quote_amount_i     (quote_amount_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .accepted_o         (accepted_o),
    .spent_total_o      (spent_total_o),
    .base_total_o       (base_total_o),
    .depth_used_o       (depth_used_o),
    .filled_all_o       (filled_all_o),
    .top_price_o        (top_price_o),
    .average_price_o    (average_price_o),
    .slippage_percent_o (slippage_percent_o)
  );

endmodule

// ===== src/obsf_checker.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module obsf_checker
  import obsf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              accepted_o,
  input logic [QuoteW-1:0] spent_total_o,
  input logic [CountW-1:0] depth_used_o,
  input logic              filled_all_o
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A refused request carries no sweep figures.
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> spent_total_o == '0 && depth_used_o == '0)
    else $error("refused request carries sweep figures");

  // A stalled result keeps its payload.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(accepted_o) && $stable(spent_total_o) &&
      $stable(depth_used_o) && $stable(filled_all_o))
    else $error("result payload changed while stalled");

  // The sweep never exceeds the table depth.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> depth_used_o <= 7'd64)
    else $error("levels used beyond table depth");

endmodule

bind order_book_sweep_fill_unit obsf_checker u_obsf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .accepted_o     (accepted_o),
  .spent_total_o  (spent_total_o),
  .depth_used_o   (depth_used_o),
  .filled_all_o   (filled_all_o)
);

// ===== tb/order_book_sweep_fill_unit_test.sv =====
// ----------------------------------------------------------------------------
// Order book sweep fill unit testbench
// Loads bid and ask levels and runs fill queries against them. A behavioral
// model of the sweep predicts every result, and the monitor compares each
// result with the oldest prediction. The run passes through phases of no
// idling, sender gaps, receiver stalls and both together.
// ----------------------------------------------------------------------------
module order_book_sweep_fill_unit_test;
  import obsf_pkg::*;

  localparam int unsigned Depth      = 64;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 600;

  typedef struct {
    logic              req;
    logic              buy;
    logic [5:0]        idx;
    logic [PriceW-1:0] price;
    logic [SizeW-1:0]  size;
    logic [QuoteW-1:0] quote;
  } book_req_t;

  typedef struct packed {
    logic              acc;
    logic [QuoteW-1:0] spent;
    logic [SizeW-1:0]  base;
    logic [CountW-1:0] used;
    logic              full;
    logic [PriceW-1:0] best;
    logic [PriceW-1:0] avg;
    logic [SlipW-1:0]  slip;
  } fill_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic ask_side = 1'b0;
  logic [5:0] level_index = '0;
  logic [PriceW-1:0] level_price = '0;
  logic [SizeW-1:0] level_size = '0;
  logic [QuoteW-1:0] quote_amount = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic accepted;
  logic [QuoteW-1:0] spent_total;
  logic [SizeW-1:0] base_total;
  logic [CountW-1:0] depth_used;
  logic filled_all;
  logic [PriceW-1:0] top_price;
  logic [PriceW-1:0] average_price;
  logic signed [SlipW-1:0] slippage_percent;

  book_req_t pending_reqs[$];
  fill_res_t expected_fills[$];
  book_req_t cur_req;
  int unsigned total_reqs = 0;
  int unsigned sent_reqs = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Predictor copy of the book.
  logic [PriceW-1:0] book_price[2*Depth];
  logic [SizeW-1:0]  book_size[2*Depth];
  int unsigned       bid_count = 0;
  int unsigned       ask_count = 0;

  order_book_sweep_fill_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .ask_side_i        (ask_side),
    .level_index_i     (level_index),
    .level_price_i     (level_price),
    .level_size_i      (level_size),
    .quote_amount_i    (quote_amount),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .accepted_o        (accepted),
    .spent_total_o     (spent_total),
    .base_total_o      (base_total),
    .depth_used_o      (depth_used),
    .filled_all_o      (filled_all),
    .top_price_o       (top_price),
    .average_price_o   (average_price),
    .slippage_percent_o(slippage_percent)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends one request to the pending queue.
  function automatic void add_req(book_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Random value with a random number of significant bits, sometimes all ones.
  function automatic logic [63:0] rand_bits(int unsigned w);
    logic [63:0] v;
    int unsigned k;
    v = {$urandom, $urandom};
    k = $urandom_range(1, w);
    if ($urandom_range(0, 15) == 0) k = w;
    if ($urandom_range(0, 31) == 0) v = '1;
    return v & ((64'd1 << k) - 64'd1);
  endfunction

  // floor(a * 2^32 / d), limited to lim; zero for a zero divisor.
  function automatic logic [63:0] div_shift32(logic [63:0] a, logic [63:0] d,
                                              logic [63:0] lim);
    logic [127:0] q;
    if (d == 0) return 64'd0;
    q = {32'd0, a, 32'd0} / {64'd0, d};
    return (q > {64'd0, lim}) ? lim : q[63:0];
  endfunction

  // Applies one request to the book and returns the result it causes.
  function automatic fill_res_t sweep_fill(book_req_t r);
    fill_res_t   res;
    int unsigned at, count, n;
    logic [87:0] prod;
    logic [63:0] rem, spent, base, cost, best, avg, diff, mag;
    logic        neg;
    res = '0;
    at = r.buy ? Depth : 0;
    if (r.req == REQ_LOAD) begin
      if (r.price == 0 || r.size == 0 || r.idx >= Depth) return res;
      book_price[at + r.idx] = r.price;
      book_size[at + r.idx] = r.size;
      if (r.buy) ask_count = r.idx + 1;
      else bid_count = r.idx + 1;
      res.acc = 1'b1;
      return res;
    end
    count = r.buy ? ask_count : bid_count;
    if (count == 0) return res;
    best = 64'(book_price[at]);
    rem = 64'(r.quote);
    spent = 0;
    base = 0;
    avg = 0;
    mag = 0;
    for (n = 0; n < count && rem != 0; n++) begin
      prod = 88'(book_price[at + n]) * 88'(book_size[at + n]);
      cost = 64'(prod[87:32]);
      if (rem >= cost) begin
        spent += cost;
        base += 64'(book_size[at + n]);
        rem -= cost;
      end else begin
        spent += rem;
        base += div_shift32(rem, 64'(book_price[at + n]), 64'hFFFF_FFFF_FFFF);
        rem = 0;
      end
    end
    if (base != 0) avg = div_shift32(spent, base, 64'hFF_FFFF_FFFF);
    res.acc = 1'b1;
    res.spent = spent[47:0];
    res.base = (base > 64'hFFFF_FFFF_FFFF) ? '1 : base[47:0];
    res.used = n[6:0];
    res.full = (rem == 0);
    res.best = best[39:0];
    res.avg = avg[39:0];
    // Slippage is signed against the best price and saturates.
    if (best != 0 && avg != 0) begin
      neg = r.buy ? (avg < best) : (best < avg);
      diff = (avg >= best) ? avg - best : best - avg;
      mag = diff * 64'(SLIP_SCALE) / best;
      if (neg) begin
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        res.slip = -mag[31:0];
      end else begin
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        res.slip = mag[31:0];
      end
    end
    return res;
  endfunction

  // Driver: presents pending requests and predicts each accepted one.
  always @(posedge clk) begin
    int unsigned mode;
    logic        idle;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_fills.insert(expected_fills.size(), sweep_fill(cur_req));
        sent_reqs++;
      end
      if (!(in_valid && in_stall)) begin
        mode = (total_reqs == 0) ? 0 : (sent_reqs * 4) / total_reqs;
        idle = (mode == 1) ? ($urandom_range(0, 99) < 74) :
               (mode == 3) ? ($urandom_range(0, 99) < 36) : 1'b0;
        if (pending_reqs.size() != 0 && !idle) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_req.req;
          ask_side <= cur_req.buy;
          level_index <= cur_req.idx;
          level_price <= cur_req.price;
          level_size <= cur_req.size;
          quote_amount <= cur_req.quote;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the receiver stall.
  always @(posedge clk) begin
    fill_res_t exp_res, got;
    int unsigned mode;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{accepted, spent_total, base_total, depth_used, filled_all,
                top_price, average_price, slippage_percent};
        if (expected_fills.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result: %p", got);
        end else begin
          exp_res = expected_fills.pop_front();
          if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Result mismatch:\n  expected %p\n  actual   %p", exp_res, got);
          end
        end
      end
      mode = (total_reqs == 0) ? 0 : (sent_reqs * 4) / total_reqs;
      out_stall <= (mode == 2) ? ($urandom_range(0, 99) < 74) :
                   (mode == 3) ? ($urandom_range(0, 99) < 36) : 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL order_book_sweep_fill_unit");
      $finish;
    end
  end

  initial begin
    int unsigned prefix[2];
    book_req_t   r;
    int unsigned pick, hi;

    // Directed: empty side, extremes, refused loads, saturation, zero cost.
    add_req('{REQ_QUERY, 1'b1, 6'd0, '1, '1, 48'd1000});
    add_req('{REQ_LOAD, 1'b0, 6'd0, '0, '1, '1});
    add_req('{REQ_LOAD, 1'b0, 6'd0, '1, '0, '1});
    add_req('{REQ_LOAD, 1'b0, 6'd0, '1, '1, '0});
    add_req('{REQ_QUERY, 1'b0, 6'd0, '0, '0, '0});
    add_req('{REQ_QUERY, 1'b0, 6'd0, '0, '0, '1});
    add_req('{REQ_QUERY, 1'b0, 6'd0, '0, '0, 48'd1});
    add_req('{REQ_LOAD, 1'b1, 6'd0, 40'd1, '1, '0});
    add_req('{REQ_LOAD, 1'b1, 6'd1, 40'd1, '1, '0});
    add_req('{REQ_LOAD, 1'b1, 6'd2, 40'd1, 48'd1, '0});
    add_req('{REQ_QUERY, 1'b1, 6'd0, '0, '0, '1});
    add_req('{REQ_QUERY, 1'b1, 6'd0, '0, '0, 48'd70000});
    add_req('{REQ_LOAD, 1'b1, 6'd1, 40'h10_0000, 48'h1_0000_0000, '0});
    add_req('{REQ_QUERY, 1'b1, 6'd0, '0, '0, '1});
    // The bid side is filled from its best level upward.
    add_req('{REQ_LOAD, 1'b0, 6'd0, 40'h2_0000, 48'h1_0000_0000, '0});
    add_req('{REQ_LOAD, 1'b0, 6'd1, 40'h1_0000, 48'h8_0000_0000, '0});
    add_req('{REQ_QUERY, 1'b0, 6'd0, '0, '0, 48'h7F_FFFF_FFFF});
    add_req('{REQ_QUERY, 1'b0, 6'd63, '1, '1, '0});
    // Zero-cost and sub-unit levels on the bid side.
    add_req('{REQ_LOAD, 1'b0, 6'd2, 40'd1, 48'd1, '0});
    add_req('{REQ_QUERY, 1'b0, 6'd0, '0, '0, '1});
    prefix[0] = 3;
    prefix[1] = 3;

    // Random: mostly well-formed loads and queries, some refused loads.
    for (int i = 0; i < 400; i++) begin
      r.req = REQ_LOAD;
      r.buy = 1'($urandom_range(0, 1));
      r.idx = 6'($urandom);
      r.price = PriceW'(rand_bits(PriceW));
      r.size = SizeW'(rand_bits(SizeW));
      r.quote = QuoteW'(rand_bits(QuoteW));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if ($urandom_range(0, 1)) r.price = '0;
        else r.size = '0;
      end else if (pick < 55) begin
        // Never leave a hole below the loaded index.
        hi = (prefix[r.buy] > Depth - 1) ? Depth - 1 : prefix[r.buy];
        r.idx = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, hi) :
                (hi > 6 ? $urandom_range(hi - 6, hi) : $urandom_range(0, hi)));
        if ($urandom_range(0, 3) != 0) begin
          r.price = PriceW'({$urandom} & 32'hFF_FFFF);
          r.size = SizeW'({$urandom, $urandom} & 64'hFF_FFFF_FFFF);
        end
        if (r.price == 0) r.price = 40'd1;
        if (r.size == 0) r.size = 48'd1;
        if (r.idx == prefix[r.buy]) prefix[r.buy]++;
      end else begin
        r.req = REQ_QUERY;
      end
      add_req(r);
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() == 0 && !in_valid && expected_fills.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && expected_fills.size() == 0)
      $display("PASS order_book_sweep_fill_unit");
    else
      $display("FAIL order_book_sweep_fill_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/obsf_pkg.sv
src/obsf_div.sv
src/obsf_datapath.sv
src/obsf_ctrl.sv
src/order_book_sweep_fill_unit.sv
src/obsf_checker.sv
tb/order_book_sweep_fill_unit_test.sv
